### hw/rtl/mlfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler package
// Shared constants, codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package mlfs_pkg;

  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_ID_BITS     = 16;
  localparam int DEF_AGE_BITS    = 12;

  localparam int CFG_W   = 12;
  localparam int THR_W   = 12;
  localparam int QNT_W   = 4;
  localparam int KIND_W  = 2;
  localparam int LEVEL_W = 2;
  localparam int CIDX_W  = 2;

  localparam logic [THR_W-1:0] RST_MID_AGE = 12'd1004;
  localparam logic [THR_W-1:0] RST_LOW_AGE = 12'd1001;
  localparam logic [QNT_W-1:0] RST_MID_QNT = 4'd4;
  localparam logic [QNT_W-1:0] RST_LOW_QNT = 4'd1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_NEXT   = 2'd2,
    KIND_TICK   = 2'd3
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    REG_MID_AGE = 2'd0,
    REG_LOW_AGE = 2'd1,
    REG_MID_QNT = 2'd2,
    REG_LOW_QNT = 2'd3
  } cfg_reg_t;

  localparam logic [LEVEL_W-1:0] LVL_TOP = 2'd0;
  localparam logic [LEVEL_W-1:0] LVL_MID = 2'd1;
  localparam logic [LEVEL_W-1:0] LVL_LOW = 2'd2;
  localparam logic [LEVEL_W-1:0] LVL_BAD = 2'd3;

  typedef struct packed {
    logic                load;
    logic                add;
    logic                next;
    logic                age;
    logic                scan_init;
    logic [LEVEL_W-1:0]  scan_q;
    logic                idx_inc;
    logic                promote;
    logic                shift_init;
    logic                shift_step;
    logic                drop;
    logic                set_ok;
    logic                fin;
  } mlfs_cmd_t;

  typedef struct packed {
    logic idx_end;
    logic hit;
    logic age_ge;
    logic room;
    logic shift_end;
  } mlfs_stat_t;

endpackage

### hw/rtl/mlfs_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Queue stores, heads and counts, scan and shift pointers, config and results.
// ----------------------------------------------------------------------------
module mlfs_datapath import mlfs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [ID_BITS-1:0]  in_proc_id,
  input  logic [LEVEL_W-1:0]  in_level,
  input  logic                cfg_valid,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  mlfs_cmd_t           cmd,
  output mlfs_stat_t          stat,
  output logic                out_valid,
  output logic                out_ok,
  output logic [ID_BITS-1:0]  out_chosen_id,
  output logic [QNT_W-1:0]    out_quantum,
  output logic                out_has_work
);

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int TW = (AGE_BITS > THR_W) ? AGE_BITS : THR_W;
  localparam logic [CW-1:0]       DEPTH_C = CW'(QUEUE_DEPTH);
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] h, input logic [CW-1:0] p);
    logic [SW-1:0] s;
    s = SW'(h) + SW'(p);
    if (s >= SW'(QUEUE_DEPTH)) s = s - SW'(QUEUE_DEPTH);
    return s[IW-1:0];
  endfunction

  logic [ID_BITS-1:0]  top_ids  [QUEUE_DEPTH];
  logic [ID_BITS-1:0]  mid_ids  [QUEUE_DEPTH];
  logic [AGE_BITS-1:0] mid_ages [QUEUE_DEPTH];
  logic [ID_BITS-1:0]  low_ids  [QUEUE_DEPTH];
  logic [AGE_BITS-1:0] low_ages [QUEUE_DEPTH];

  logic [IW-1:0] head_r [3];
  logic [IW-1:0] head_nxt [3];
  logic [CW-1:0] cnt_r [3];
  logic [CW-1:0] cnt_nxt [3];

  logic [ID_BITS-1:0] key_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic [LEVEL_W-1:0] sel_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      sp_r;
  logic               sp_act_r;
  logic               ok_r;
  logic [ID_BITS-1:0] chosen_r;
  logic [QNT_W-1:0]   quant_r;

  logic [THR_W-1:0] mid_thr_r, low_thr_r;
  logic [QNT_W-1:0] mid_qnt_r, low_qnt_r;

  logic               out_valid_r, out_ok_r, out_has_work_r;
  logic [ID_BITS-1:0] out_id_r;
  logic [QNT_W-1:0]   out_qnt_r;

  // Read side.
  logic [LEVEL_W-1:0]  nq, rd_q, tgt_q, wr_q;
  logic                any_work;
  logic [CW-1:0]       sp_inc, rd_pos, wr_pos;
  logic [IW-1:0]       rd_head, wr_head, rd_slot, wr_slot;
  logic [ID_BITS-1:0]  rd_id, wr_id;
  logic [AGE_BITS-1:0] rd_age, wr_age;
  logic [CW-1:0]       cnt_sel, cnt_tgt, cnt_lvl, cnt_nq;
  logic [THR_W-1:0]    thr;
  logic                add_ok, wr_en;
  logic                inc_en, dec_en, hinc_en;
  logic [LEVEL_W-1:0]  inc_q, dec_q;

  assign any_work = (cnt_r[0] != '0) || (cnt_r[1] != '0) || (cnt_r[2] != '0);
  assign nq = (cnt_r[0] != '0) ? LVL_TOP : ((cnt_r[1] != '0) ? LVL_MID : LVL_LOW);
  assign rd_q  = cmd.next ? nq : sel_r;
  assign tgt_q = LEVEL_W'(sel_r - LEVEL_W'(1));
  assign sp_inc = sp_r + CW'(1);
  assign rd_pos = cmd.next ? '0 : (sp_act_r ? sp_inc : idx_r);

  always_comb begin
    rd_head = head_r[0];
    wr_head = head_r[0];
    cnt_sel = cnt_r[0];
    cnt_tgt = cnt_r[0];
    cnt_lvl = cnt_r[0];
    cnt_nq  = cnt_r[0];
    for (int q = 0; q < 3; q++) begin
      if (rd_q == LEVEL_W'(q)) rd_head = head_r[q];
      if (wr_q == LEVEL_W'(q)) wr_head = head_r[q];
      if (sel_r == LEVEL_W'(q)) cnt_sel = cnt_r[q];
      if (tgt_q == LEVEL_W'(q)) cnt_tgt = cnt_r[q];
      if (lvl_r == LEVEL_W'(q)) cnt_lvl = cnt_r[q];
      if (nq == LEVEL_W'(q)) cnt_nq = cnt_r[q];
    end
  end

  assign rd_slot = wrap(rd_head, rd_pos);

  always_comb begin
    case (rd_q)
      LVL_TOP: rd_id = top_ids[rd_slot];
      LVL_MID: rd_id = mid_ids[rd_slot];
      default: rd_id = low_ids[rd_slot];
    endcase
    rd_age = (rd_q == LVL_MID) ? mid_ages[rd_slot] : low_ages[rd_slot];
  end

  assign thr = (sel_r == LVL_MID) ? mid_thr_r : low_thr_r;

  assign stat.idx_end   = (idx_r >= cnt_sel);
  assign stat.hit       = (rd_id == key_r);
  assign stat.age_ge    = (TW'(rd_age) >= TW'(thr));
  assign stat.room      = (cnt_tgt < DEPTH_C);
  assign stat.shift_end = (sp_inc >= cnt_sel);

  assign add_ok = (lvl_r != LVL_BAD) && (cnt_lvl < DEPTH_C);

  // Write side: one store write per cycle, except the parallel aging pass.
  always_comb begin
    wr_en  = 1'b0;
    wr_q   = sel_r;
    wr_pos = idx_r;
    wr_id  = rd_id;
    wr_age = '0;
    if (cmd.add && add_ok) begin
      wr_en  = 1'b1;
      wr_q   = lvl_r;
      wr_pos = cnt_lvl;
      wr_id  = key_r;
    end else if (cmd.next && any_work && (nq != LVL_TOP)) begin
      // Rotation: the head entry is copied to the tail with a fresh age.
      wr_en  = 1'b1;
      wr_q   = nq;
      wr_pos = cnt_nq;
    end else if (cmd.promote) begin
      wr_en  = 1'b1;
      wr_q   = tgt_q;
      wr_pos = cnt_tgt;
    end else if (cmd.shift_step) begin
      wr_en  = 1'b1;
      wr_q   = sel_r;
      wr_pos = sp_r;
      wr_age = rd_age;
    end
  end

  assign wr_slot = wrap(wr_head, wr_pos);

  always_ff @(posedge clk) begin
    if (cmd.age) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (mid_ages[i] != AGE_MAX) mid_ages[i] <= mid_ages[i] + AGE_BITS'(1);
        if (low_ages[i] != AGE_MAX) low_ages[i] <= low_ages[i] + AGE_BITS'(1);
      end
    end else if (wr_en) begin
      case (wr_q)
        LVL_TOP: top_ids[wr_slot] <= wr_id;
        LVL_MID: begin
          mid_ids[wr_slot]  <= wr_id;
          mid_ages[wr_slot] <= wr_age;
        end
        default: begin
          low_ids[wr_slot]  <= wr_id;
          low_ages[wr_slot] <= wr_age;
        end
      endcase
    end
  end

  // Counts and heads.
  always_comb begin
    inc_en  = (cmd.add && add_ok) || cmd.promote;
    inc_q   = cmd.promote ? tgt_q : lvl_r;
    dec_en  = (cmd.next && (cnt_r[0] != '0)) || cmd.drop;
    dec_q   = cmd.drop ? sel_r : LVL_TOP;
    hinc_en = cmd.next && any_work;
    for (int q = 0; q < 3; q++) begin
      cnt_nxt[q]  = cnt_r[q];
      head_nxt[q] = head_r[q];
      if (inc_en && (inc_q == LEVEL_W'(q))) cnt_nxt[q] = cnt_r[q] + CW'(1);
      else if (dec_en && (dec_q == LEVEL_W'(q))) cnt_nxt[q] = cnt_r[q] - CW'(1);
      if (hinc_en && (nq == LEVEL_W'(q))) head_nxt[q] = wrap(head_r[q], CW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int q = 0; q < 3; q++) begin
        cnt_r[q]  <= '0;
        head_r[q] <= '0;
      end
      sp_act_r    <= 1'b0;
      sel_r       <= LVL_MID;
      out_valid_r <= 1'b0;
      mid_thr_r   <= RST_MID_AGE;
      low_thr_r   <= RST_LOW_AGE;
      mid_qnt_r   <= RST_MID_QNT;
      low_qnt_r   <= RST_LOW_QNT;
    end else begin
      for (int q = 0; q < 3; q++) begin
        cnt_r[q]  <= cnt_nxt[q];
        head_r[q] <= head_nxt[q];
      end
      if (cmd.scan_init) sel_r <= cmd.scan_q;
      if (cmd.shift_init) sp_act_r <= 1'b1;
      else if (cmd.drop) sp_act_r <= 1'b0;
      out_valid_r <= cmd.fin;
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_MID_AGE: mid_thr_r <= cfg_data[THR_W-1:0];
          REG_LOW_AGE: low_thr_r <= cfg_data[THR_W-1:0];
          REG_MID_QNT: mid_qnt_r <= cfg_data[QNT_W-1:0];
          REG_LOW_QNT: low_qnt_r <= cfg_data[QNT_W-1:0];
          default:     mid_thr_r <= mid_thr_r;
        endcase
      end
    end
  end

  // Transaction payload and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= in_proc_id;
      lvl_r    <= in_level;
      ok_r     <= 1'b0;
      chosen_r <= '0;
      quant_r  <= '0;
    end
    if (cmd.add) ok_r <= add_ok;
    if (cmd.next && any_work) begin
      ok_r     <= 1'b1;
      chosen_r <= rd_id;
      case (nq)
        LVL_MID: quant_r <= mid_qnt_r;
        LVL_LOW: quant_r <= low_qnt_r;
        default: quant_r <= '0;
      endcase
    end
    if (cmd.set_ok) ok_r <= 1'b1;
    if (cmd.scan_init) idx_r <= '0;
    else if (cmd.idx_inc) idx_r <= idx_r + CW'(1);
    if (cmd.shift_init) sp_r <= idx_r;
    else if (cmd.shift_step) sp_r <= sp_inc;
    if (cmd.fin) begin
      out_ok_r       <= ok_r;
      out_id_r       <= chosen_r;
      out_qnt_r      <= quant_r;
      out_has_work_r <= any_work;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_ok        = out_ok_r;
  assign out_chosen_id = out_id_r;
  assign out_quantum   = out_qnt_r;
  assign out_has_work  = out_has_work_r;

endmodule

### hw/rtl/mlfs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences add, remove, next and tick operations over the datapath.
// ----------------------------------------------------------------------------
module mlfs_ctrl import mlfs_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [KIND_W-1:0] in_kind,
  input  mlfs_stat_t        stat,
  output logic              busy,
  output mlfs_cmd_t         cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ADD   = 8'b0000_0010,
    S_NEXT  = 8'b0000_0100,
    S_AGE   = 8'b0000_1000,
    S_RSCAN = 8'b0001_0000,
    S_PSCAN = 8'b0010_0000,
    S_SHIFT = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   lev2_r, lev2_nxt;
  logic   rm_r, rm_nxt;

  always_comb begin
    state_nxt = state_r;
    lev2_nxt  = lev2_r;
    rm_nxt    = rm_r;
    cmd       = '0;
    cmd.scan_q = LVL_MID;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          unique case (kind_t'(in_kind))
            KIND_ADD:  state_nxt = S_ADD;
            KIND_NEXT: state_nxt = S_NEXT;
            KIND_REMOVE: begin
              cmd.scan_init = 1'b1;
              lev2_nxt      = 1'b0;
              rm_nxt        = 1'b1;
              state_nxt     = S_RSCAN;
            end
            default: begin
              rm_nxt    = 1'b0;
              state_nxt = S_AGE;
            end
          endcase
        end
      end
      S_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = S_DONE;
      end
      S_NEXT: begin
        cmd.next  = 1'b1;
        state_nxt = S_DONE;
      end
      S_AGE: begin
        cmd.age       = 1'b1;
        cmd.scan_init = 1'b1;
        lev2_nxt      = 1'b0;
        state_nxt     = S_PSCAN;
      end
      S_RSCAN: begin
        if (stat.idx_end) begin
          if (!lev2_r) begin
            cmd.scan_init = 1'b1;
            cmd.scan_q    = LVL_LOW;
            lev2_nxt      = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.hit) begin
          cmd.set_ok     = 1'b1;
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_PSCAN: begin
        if (stat.idx_end) begin
          if (!lev2_r) begin
            cmd.scan_init = 1'b1;
            cmd.scan_q    = LVL_LOW;
            lev2_nxt      = 1'b1;
          end else begin
            state_nxt = S_DONE;
          end
        end else if (stat.age_ge && stat.room) begin
          cmd.promote    = 1'b1;
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        // Close the gap one entry per cycle; a promotion scan then resumes
        // at the same position, which now holds the following entry.
        if (stat.shift_end) begin
          cmd.drop  = 1'b1;
          state_nxt = rm_r ? S_DONE : S_PSCAN;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_DONE: begin
        cmd.fin   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      lev2_r  <= 1'b0;
      rm_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lev2_r  <= lev2_nxt;
      rm_r    <= rm_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

### hw/rtl/multilevel_feedback_scheduler_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multilevel feedback scheduler
// Three-level queue scheduler: first-come top level, two aging round-robin
// levels with promotion on tick.
//
//   Channel   Handshake              Payload
//   input     start && !busy         in_kind, in_proc_id, in_level
//   result    out_valid (one cycle)  out_ok, out_chosen_id, out_quantum,
//                                    out_has_work
//   config    cfg_valid && cfg_ready cfg_index, cfg_data
//
// Add and next pass through their operation state and S_DONE before the
// registered result strobe. Remove walks level 1 then level 2 one entry a
// cycle and closes the gap one entry a cycle. Tick ages all entries in
// parallel, then scans both levels; each promotion costs a gap-closing walk.
// Reset clears all counts and heads; stores need no clearing. Results
// cannot be stalled; cfg_ready is always high.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_top import mlfs_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int ID_BITS     = DEF_ID_BITS,
  parameter int AGE_BITS    = DEF_AGE_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic [ID_BITS-1:0]  in_proc_id,
  input  logic [LEVEL_W-1:0]  in_level,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CIDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  output logic                out_valid,
  output logic                out_ok,
  output logic [ID_BITS-1:0]  out_chosen_id,
  output logic [QNT_W-1:0]    out_quantum,
  output logic                out_has_work
);

  mlfs_cmd_t  cmd;
  mlfs_stat_t stat;

  assign cfg_ready = 1'b1;

  mlfs_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  mlfs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .AGE_BITS    (AGE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_proc_id    (in_proc_id),
    .in_level      (in_level),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_valid     (out_valid),
    .out_ok        (out_ok),
    .out_chosen_id (out_chosen_id),
    .out_quantum   (out_quantum),
    .out_has_work  (out_has_work)
  );

endmodule

### hw/rtl/mlfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level properties of the scheduler, attached to the top level by bind.
// ----------------------------------------------------------------------------
module mlfs_checker import mlfs_pkg::*; #(
  parameter int ID_BITS = DEF_ID_BITS
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic               out_ok,
  input logic [ID_BITS-1:0] out_chosen_id,
  input logic [QNT_W-1:0]   out_quantum
);

  // Each accepted transaction keeps the block busy on the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");

  // A result strobe only appears once the block is ready for more work.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  // A failed transaction carries no chosen process and no quantum.
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok) |-> (out_chosen_id == '0) && (out_quantum == '0))
    else $error("failed result carries a process");

  // A granted quantum implies a successful next.
  a_qnt_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_quantum != '0)) |-> out_ok)
    else $error("quantum without success");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid)) else $error("reset left block active");

endmodule

bind multilevel_feedback_scheduler_top mlfs_checker #(.ID_BITS(ID_BITS)) u_mlfs_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_ok        (out_ok),
  .out_chosen_id (out_chosen_id),
  .out_quantum   (out_quantum)
);
